// ===== sv/centrifuge_speed_alarm_monitor_unit_macros.svh =====
// Assertion macros shared by the checker of the centrifuge speed alarm monitor.
// Depends on nothing; the user supplies clk and rst_n in scope.
`ifndef CENTRIFUGE_SPEED_ALARM_MONITOR_UNIT_MACROS_SVH
`define CENTRIFUGE_SPEED_ALARM_MONITOR_UNIT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define CSAM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define CSAM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/csam_pkg.sv =====
// Types and constants of the centrifuge speed alarm monitor.
// Used by the top level and its checker; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package csam_pkg;

  localparam int SPEED_W  = 14;
  localparam int CNT_W    = 5;
  localparam int TICK_W   = 7;
  localparam int REMAIN_W = SPEED_W + TICK_W;
  localparam int CFG_IDX_W = 2;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_MAX_SPEED     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_RUN_SPEED = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_BAND    = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [SPEED_W-1:0] MAX_SPEED_RST     = 14'd3000;
  localparam logic [SPEED_W-1:0] MIN_RUN_SPEED_RST = 14'd100;
  localparam logic [SPEED_W-1:0] SPEED_BAND_RST    = 14'd100;

  typedef enum logic {
    KIND_SAMPLE = 1'b0,
    KIND_TICK   = 1'b1
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [SPEED_W-1:0] command_rpm;
    logic [SPEED_W-1:0] measured_rpm;
    logic               power_good;
    logic               hw_error;
    logic               integration_error;
  } in_item_t;

  typedef struct packed {
    logic overspeed_alarm;
    logic hardware_alarm;
    logic integral_alarm;
    logic integration_seen;
  } out_item_t;

endpackage

`default_nettype wire

// ===== sv/centrifuge_speed_alarm_monitor_unit.sv =====
// An accepted item passes the input register and then the result register. One item
// per cycle while out_stall is low; the alarm state (power loss count, last command,
// watchdog) is updated in the single compare-and-multiply stage after the input register.
// An input register and a result register part the channels, so input is taken while
// a result waits. Reset (rst_n low, synchronous) clears all state, empties both
// registers and loads the configuration registers with their default values.
`timescale 1ns / 1ps
`default_nettype none

module centrifuge_speed_alarm_monitor_unit #(
  parameter int POWER_LOSS_LIMIT = 20,
  parameter int TICKS_PER_RPM    = 100
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire csam_pkg::in_item_t          in_data,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output csam_pkg::out_item_t              out_data,
  input  wire logic                        cfg_we,
  input  wire logic [csam_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [csam_pkg::SPEED_W-1:0]   cfg_wdata
);

  import csam_pkg::*;

  localparam logic [CNT_W-1:0]  CNT_LIMIT  = CNT_W'(POWER_LOSS_LIMIT);
  localparam logic [TICK_W-1:0] TICK_MULT  = TICK_W'(TICKS_PER_RPM);

  // Configuration registers.
  logic [SPEED_W-1:0] max_speed_r, min_run_speed_r, speed_band_r;

  // Pipeline registers.
  logic      s1_valid_r, s1_valid_nxt;
  in_item_t  s1_item_r;
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_item_r, out_item_nxt;

  // Alarm state.
  logic [CNT_W-1:0]    loss_cnt_r, loss_cnt_nxt;
  logic [SPEED_W-1:0]  last_cmd_r, last_cmd_nxt;
  logic                wd_run_r, wd_run_nxt;
  logic [REMAIN_W-1:0] wd_remain_r, wd_remain_nxt;
  logic                integ_r, integ_nxt;

  // Handshake control.
  logic s1_go;
  logic in_take;

  // Datapath terms for the item in the input register.
  logic [SPEED_W:0]            cmd_ext, meas_ext, band_ext;
  logic [SPEED_W:0]            max_plus_one;
  logic [SPEED_W:0]            meas_plus_band, cmd_plus_band;
  logic [SPEED_W+TICK_W-1:0]   arm_load;
  logic                        running, out_of_band;
  logic [CNT_W-1:0]            cnt_inc;
  logic [REMAIN_W-1:0]         remain_dec;
  logic                        run_tmp;

  assign s1_go     = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && !s1_go;
  assign in_take   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

  assign cmd_ext        = {1'b0, s1_item_r.command_rpm};
  assign meas_ext       = {1'b0, s1_item_r.measured_rpm};
  assign band_ext       = {1'b0, speed_band_r};
  assign max_plus_one   = {1'b0, max_speed_r} + (SPEED_W+1)'(1);
  assign meas_plus_band = meas_ext + band_ext;
  assign cmd_plus_band  = cmd_ext + band_ext;
  assign arm_load       = REMAIN_W'(s1_item_r.command_rpm) * REMAIN_W'(TICK_MULT);
  assign running        = s1_item_r.command_rpm >= min_run_speed_r;
  assign out_of_band    = (cmd_ext > meas_plus_band) || (cmd_plus_band < meas_ext);
  assign cnt_inc        = loss_cnt_r + CNT_W'(1);
  assign remain_dec     = wd_remain_r - REMAIN_W'(1);

  // Handshake next state for the two registers.
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_go) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s1_go) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Alarm evaluation and state update for the item in the input register.
  always_comb begin
    loss_cnt_nxt  = loss_cnt_r;
    last_cmd_nxt  = last_cmd_r;
    wd_run_nxt    = wd_run_r;
    wd_remain_nxt = wd_remain_r;
    integ_nxt     = integ_r;
    run_tmp       = wd_run_r;
    out_item_nxt  = '0;
    unique case (s1_item_r.kind)
      KIND_TICK: begin
        // Count the armed watchdog down; expiry raises the integral alarm.
        if (wd_run_r && (wd_remain_r != '0)) begin
          wd_remain_nxt = remain_dec;
          if (remain_dec == '0) begin
            out_item_nxt.integral_alarm = 1'b1;
            wd_run_nxt = 1'b0;
          end
        end
      end
      default: begin
        out_item_nxt.overspeed_alarm = cmd_ext > max_plus_one;
        // Consecutive running commands without power.
        if (running && !s1_item_r.power_good) begin
          loss_cnt_nxt = cnt_inc;
        end else begin
          loss_cnt_nxt = '0;
        end
        if (loss_cnt_nxt > CNT_LIMIT) begin
          out_item_nxt.hardware_alarm = 1'b1;
          loss_cnt_nxt = '0;
        end
        if (s1_item_r.hw_error) begin
          out_item_nxt.hardware_alarm = 1'b1;
        end
        if (s1_item_r.integration_error) begin
          integ_nxt = 1'b1;
        end
        // A changed command restarts the watchdog.
        last_cmd_nxt = s1_item_r.command_rpm;
        if (last_cmd_r != s1_item_r.command_rpm) begin
          run_tmp = 1'b0;
        end
        // Arm when out of band, disarm when back in band.
        if (running && out_of_band) begin
          if (!run_tmp) begin
            wd_remain_nxt = REMAIN_W'(arm_load);
            wd_run_nxt    = 1'b1;
          end else begin
            wd_run_nxt    = 1'b1;
          end
        end else begin
          wd_run_nxt    = 1'b0;
          wd_remain_nxt = '0;
        end
      end
    endcase
    out_item_nxt.integration_seen = integ_nxt;
  end

  // Control and state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_speed_r     <= MAX_SPEED_RST;
      min_run_speed_r <= MIN_RUN_SPEED_RST;
      speed_band_r    <= SPEED_BAND_RST;
      s1_valid_r      <= 1'b0;
      out_valid_r     <= 1'b0;
      loss_cnt_r      <= '0;
      last_cmd_r      <= '0;
      wd_run_r        <= 1'b0;
      wd_remain_r     <= '0;
      integ_r         <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_MAX_SPEED:     max_speed_r     <= cfg_wdata;
          REG_MIN_RUN_SPEED: min_run_speed_r <= cfg_wdata;
          REG_SPEED_BAND:    speed_band_r    <= cfg_wdata;
          default: ;
        endcase
      end
      if (s1_go) begin
        loss_cnt_r  <= loss_cnt_nxt;
        last_cmd_r  <= last_cmd_nxt;
        wd_run_r    <= wd_run_nxt;
        wd_remain_r <= wd_remain_nxt;
        integ_r     <= integ_nxt;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item_r <= in_data;
    end
    if (s1_go) begin
      out_item_r <= out_item_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== sv/csam_checker.sv =====
// Port-level checker for the centrifuge speed alarm monitor, bound to the top level.
// Depends on csam_pkg and the assertion macros header.
`timescale 1ns / 1ps
`default_nettype none

`include "centrifuge_speed_alarm_monitor_unit_macros.svh"

module csam_checker (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_valid,
  input wire logic                in_stall,
  input wire logic                out_valid,
  input wire logic                out_stall,
  input wire csam_pkg::out_item_t out_data
);

  import csam_pkg::*;

  logic       in_fire, out_fire;
  logic [1:0] pending_r, pending_nxt;
  logic       seen_r;

  assign in_fire  = in_valid && !in_stall;
  assign out_fire = out_valid && !out_stall;

  // Items taken in but not yet delivered.
  always_comb begin
    pending_nxt = pending_r;
    if (in_fire && !out_fire) begin
      pending_nxt = pending_r + 2'd1;
    end else if (out_fire && !in_fire) begin
      pending_nxt = pending_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
      seen_r    <= 1'b0;
    end else begin
      pending_r <= pending_nxt;
      if (out_fire && out_data.integration_seen) begin
        seen_r <= 1'b1;
      end
    end
  end

  `CSAM_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "stalled result changed")
  `CSAM_ASSERT_NOW(a_tick_only, out_valid && out_data.integral_alarm, !out_data.overspeed_alarm && !out_data.hardware_alarm, "integral alarm together with a sample alarm")
  `CSAM_ASSERT_NOW(a_sticky, out_valid && seen_r, out_data.integration_seen, "integration flag dropped")
  `CSAM_ASSERT_NOW(a_no_invent, out_valid, pending_r != 2'd0, "result without an item")
  `CSAM_ASSERT_NOW(a_depth, 1'b1, pending_r != 2'd3, "more items in flight than registers")

endmodule

bind centrifuge_speed_alarm_monitor_unit csam_checker u_csam_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire
